// ----- rtl/core/tcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text console glyph renderer: beat
// layouts, font geometry, opcodes, register indexes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcgr_pkg;

  // font geometry
  localparam int FONT_W      = 8;
  localparam int FONT_H      = 16;
  localparam int GLYPH_COUNT = 95;
  localparam int STORE_DEPTH = GLYPH_COUNT * FONT_H;

  localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
  localparam int GROW_W      = $clog2(FONT_H);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field and register widths
  localparam int COL_W       = 10;
  localparam int ROW_W       = 9;
  localparam int PIX_ROW_W   = ROW_W + GROW_W;
  localparam int PIX_COL_W   = COL_W + $clog2(FONT_W);
  localparam int SCR_W       = 13;
  localparam int STRIDE_W    = 14;
  localparam int IDX_W       = 25;
  localparam int PROD_W      = PIX_ROW_W + STRIDE_W;
  localparam int CFG_IDX_W   = 3;

  // opcodes
  localparam logic [1:0] OP_FONT_LOAD  = 2'd0;
  localparam logic [1:0] OP_WRITE_CHAR = 2'd1;
  localparam logic [1:0] OP_BEGIN      = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB_RECORDED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_MAPPED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR      = 3'd6;

  // character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7E;
  localparam logic [7:0] CH_SUBST = 8'h3F;

  localparam logic [31:0] FG_DEFAULT = 32'h00FF_FFFF;
  localparam logic [31:0] BG_DEFAULT = 32'h0000_0000;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [3:0] glyph_row;
    logic [7:0] row_bits;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] word_index;
    logic [7:0]       pattern;
    logic [31:0]      fg_value;
    logic [31:0]      bg_value;
    logic             last_row;
  } out_beat_t;

  // one character to draw
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [GLYPH_W-1:0] glyph;
  } draw_job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } font_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } font_rd_t;

  // drawing settings seen by the row generator
  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    logic [31:0]         fg;
    logic [31:0]         bg;
  } draw_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/tcgr_font.sv -----
// ----------------------------------------------------------------------------
// tcgr_font
// Font store: one glyph row per entry, one write and one registered read
// port. Entries hold nothing meaningful until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_font (
  input  wire logic              clk,
  input  wire tcgr_pkg::font_wr_t wr,
  input  wire tcgr_pkg::font_rd_t rd,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [tcgr_pkg::STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Configuration registers, opcode decode and character cursor. Each input
// beat is resolved in its accept cycle: font loads go to the store, cursor
// moves happen at once, and a drawn character is handed on as a job.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  input  wire logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                      cfg_data,
  input  wire logic                             in_fire,
  input  wire tcgr_pkg::in_beat_t               in_data,
  output tcgr_pkg::draw_job_t                   job,
  output logic                                  job_load,
  output tcgr_pkg::font_wr_t                    font_wr,
  output tcgr_pkg::draw_cfg_t                   dcfg
);

  logic [tcgr_pkg::SCR_W-1:0]    width_r, width_nxt;
  logic [tcgr_pkg::SCR_W-1:0]    height_r, height_nxt;
  logic [tcgr_pkg::STRIDE_W-1:0] stride_r, stride_nxt;
  logic                          recorded_r, recorded_nxt;
  logic                          mapped_r, mapped_nxt;
  logic [31:0]                   fg_r, fg_nxt;
  logic [31:0]                   bg_r, bg_nxt;
  logic [tcgr_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [tcgr_pkg::ROW_W-1:0]    row_r, row_nxt;

  logic [tcgr_pkg::COL_W-1:0]    cols;
  logic [tcgr_pkg::ROW_W-1:0]    rows;
  logic [tcgr_pkg::ROW_W:0]      row_inc;
  logic [tcgr_pkg::ROW_W-1:0]    nl_row;
  logic                          wrap;
  logic [tcgr_pkg::COL_W-1:0]    col_a;
  logic [tcgr_pkg::ROW_W-1:0]    row_a;
  logic                          char_ok;
  logic                          code_ok;
  logic [7:0]                    glyph_code;
  logic [7:0]                    load_idx;
  logic                          font_en;

  // cell counts of the screen
  assign cols = width_r[tcgr_pkg::SCR_W-1:3];
  assign rows = height_r[tcgr_pkg::SCR_W-1:4];

  // row after a newline, clipped to the bottom row
  assign row_inc = {1'b0, row_r} + {{tcgr_pkg::ROW_W{1'b0}}, 1'b1};
  assign nl_row  = (row_inc >= {1'b0, rows}) ? rows - 1'b1 : row_inc[tcgr_pkg::ROW_W-1:0];

  // wrap at the right edge before any character other than CR and LF
  assign wrap  = (col_r >= cols);
  assign col_a = wrap ? '0 : col_r;
  assign row_a = wrap ? nl_row : row_r;

  assign char_ok    = recorded_r && (cols != '0) && (rows != '0);
  assign code_ok    = (in_data.char_code >= tcgr_pkg::CH_FIRST) &&
                      (in_data.char_code <= tcgr_pkg::CH_LAST);
  assign glyph_code = (code_ok ? in_data.char_code : tcgr_pkg::CH_SUBST) - tcgr_pkg::CH_FIRST;
  assign load_idx   = in_data.char_code - tcgr_pkg::CH_FIRST;

  assign job.col   = col_a;
  assign job.row   = row_a;
  assign job.glyph = glyph_code[tcgr_pkg::GLYPH_W-1:0];

  assign font_wr.en   = font_en;
  assign font_wr.addr = tcgr_pkg::ADDR_W'(
                          {{(tcgr_pkg::ADDR_W-tcgr_pkg::GLYPH_W){1'b0}},
                           load_idx[tcgr_pkg::GLYPH_W-1:0]} * tcgr_pkg::ADDR_W'(tcgr_pkg::FONT_H)
                          + tcgr_pkg::ADDR_W'(in_data.glyph_row));
  assign font_wr.data = in_data.row_bits;

  assign dcfg.stride = stride_r;
  assign dcfg.fg     = fg_r;
  assign dcfg.bg     = bg_r;

  // beat decode and cursor update
  always_comb begin
    width_nxt    = width_r;
    height_nxt   = height_r;
    stride_nxt   = stride_r;
    recorded_nxt = recorded_r;
    mapped_nxt   = mapped_r;
    fg_nxt       = fg_r;
    bg_nxt       = bg_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    job_load     = 1'b0;
    font_en      = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        tcgr_pkg::REG_SCREEN_WIDTH:  width_nxt    = cfg_data[tcgr_pkg::SCR_W-1:0];
        tcgr_pkg::REG_SCREEN_HEIGHT: height_nxt   = cfg_data[tcgr_pkg::SCR_W-1:0];
        tcgr_pkg::REG_STRIDE:        stride_nxt   = cfg_data[tcgr_pkg::STRIDE_W-1:0];
        tcgr_pkg::REG_FB_RECORDED:   recorded_nxt = cfg_data[0];
        tcgr_pkg::REG_FB_MAPPED:     mapped_nxt   = cfg_data[0];
        tcgr_pkg::REG_FG_COLOR:      fg_nxt       = cfg_data;
        tcgr_pkg::REG_BG_COLOR:      bg_nxt       = cfg_data;
        default: ;
      endcase
    end

    if (in_fire) begin
      unique case (in_data.opcode)
        tcgr_pkg::OP_FONT_LOAD: begin
          font_en = code_ok &&
                    ({1'b0, in_data.glyph_row} < (tcgr_pkg::GROW_W+1)'(tcgr_pkg::FONT_H));
        end
        tcgr_pkg::OP_BEGIN: begin
          if (mapped_r && recorded_r && (width_r != '0) && (height_r != '0) &&
              (stride_r != '0)) begin
            col_nxt = tcgr_pkg::COL_W'(1);
            row_nxt = tcgr_pkg::ROW_W'(1);
            fg_nxt  = tcgr_pkg::FG_DEFAULT;
            bg_nxt  = tcgr_pkg::BG_DEFAULT;
          end
        end
        tcgr_pkg::OP_WRITE_CHAR: begin
          if (char_ok) begin
            if (in_data.char_code == tcgr_pkg::CH_CR) begin
              col_nxt = '0;
            end else if (in_data.char_code == tcgr_pkg::CH_LF) begin
              col_nxt = '0;
              row_nxt = nl_row;
            end else begin
              col_nxt = col_a;
              row_nxt = row_a;
              if (row_a < rows) begin
                col_nxt  = col_a + 1'b1;
                job_load = mapped_r && (stride_r != '0);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= '0;
      height_r   <= '0;
      stride_r   <= '0;
      recorded_r <= 1'b0;
      mapped_r   <= 1'b0;
      fg_r       <= tcgr_pkg::FG_DEFAULT;
      bg_r       <= tcgr_pkg::BG_DEFAULT;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      stride_r   <= stride_nxt;
      recorded_r <= recorded_nxt;
      mapped_r   <= mapped_nxt;
      fg_r       <= fg_nxt;
      bg_r       <= bg_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tcgr_rowgen.sv -----
// ----------------------------------------------------------------------------
// tcgr_rowgen
// Walks the glyph rows of one character: issues a font read and the pixel offset
// each cycle unless the output stalls, then a result register towards the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_rowgen (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tcgr_pkg::draw_job_t job,
  input  wire logic                job_load,
  input  wire tcgr_pkg::draw_cfg_t dcfg,
  output logic                     job_free,
  output tcgr_pkg::font_rd_t       font_rd,
  input  wire logic [7:0]          font_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tcgr_pkg::out_beat_t      out_data
);

  logic                            busy_r, busy_nxt;
  logic [tcgr_pkg::GROW_W-1:0]     y_r, y_nxt;
  tcgr_pkg::draw_job_t             job_r;
  logic                            s1_v_r, s1_v_nxt;
  logic [tcgr_pkg::IDX_W-1:0]      s1_idx_r;
  logic [31:0]                     s1_fg_r;
  logic [31:0]                     s1_bg_r;
  logic                            s1_last_r;
  logic                            out_v_r, out_v_nxt;
  tcgr_pkg::out_beat_t             out_r;

  logic                            out_move;
  logic                            s1_move;
  logic                            issue;
  logic                            y_last;
  logic [tcgr_pkg::PIX_ROW_W-1:0]  pix_row;
  logic [tcgr_pkg::PIX_COL_W-1:0]  pix_col;
  logic [tcgr_pkg::PROD_W-1:0]     idx_full;

  // handshake between the stages
  assign out_move = !out_v_r || out_ready;
  assign s1_move  = s1_v_r && out_move;
  assign issue    = busy_r && (!s1_v_r || out_move);
  assign y_last   = (y_r == tcgr_pkg::GROW_W'(tcgr_pkg::FONT_H - 1));
  assign job_free = !busy_r || (issue && y_last);

  // font read and pixel offset of the current glyph row
  assign font_rd.en   = issue;
  assign font_rd.addr = tcgr_pkg::ADDR_W'(
                          {{(tcgr_pkg::ADDR_W-tcgr_pkg::GLYPH_W){1'b0}}, job_r.glyph}
                          * tcgr_pkg::ADDR_W'(tcgr_pkg::FONT_H)
                          + tcgr_pkg::ADDR_W'(y_r));

  assign pix_row  = tcgr_pkg::PIX_ROW_W'(
                      {{tcgr_pkg::GROW_W{1'b0}}, job_r.row} * tcgr_pkg::PIX_ROW_W'(tcgr_pkg::FONT_H)
                      + tcgr_pkg::PIX_ROW_W'(y_r));
  assign pix_col  = tcgr_pkg::PIX_COL_W'(
                      {{(tcgr_pkg::PIX_COL_W-tcgr_pkg::COL_W){1'b0}}, job_r.col}
                      * tcgr_pkg::PIX_COL_W'(tcgr_pkg::FONT_W));
  assign idx_full = tcgr_pkg::PROD_W'(
                      {{tcgr_pkg::STRIDE_W{1'b0}}, pix_row} *
                      {{tcgr_pkg::PIX_ROW_W{1'b0}}, dcfg.stride})
                    + tcgr_pkg::PROD_W'(pix_col);

  // row counter and job hold
  always_comb begin
    busy_nxt = busy_r;
    y_nxt    = y_r;
    if (issue) begin
      y_nxt = y_r + 1'b1;
      if (y_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (job_load) begin
      busy_nxt = 1'b1;
      y_nxt    = '0;
    end
  end

  assign s1_v_nxt  = issue ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
  assign out_v_nxt = out_move ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      y_r     <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      y_r     <= y_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job;
    end
    if (issue) begin
      s1_idx_r  <= idx_full[tcgr_pkg::IDX_W-1:0];
      s1_fg_r   <= dcfg.fg;
      s1_bg_r   <= dcfg.bg;
      s1_last_r <= y_last;
    end
    if (s1_move) begin
      out_r.word_index <= s1_idx_r;
      out_r.pattern    <= font_data;
      out_r.fg_value   <= s1_fg_r;
      out_r.bg_value   <= s1_bg_r;
      out_r.last_row   <= s1_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/core/text_console_glyph_renderer.sv -----
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Text console with a character cursor and a loadable 8x16 font; each drawn
// character comes out as sixteen glyph-row beats of eight pixels.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    tcgr_pkg::in_beat_t
//   out_     output     out_valid / out_ready  tcgr_pkg::out_beat_t
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A drawn character occupies the font read port, one glyph row a cycle unless
// the output stalls; the next beat is taken in the cycle of its last read.
// Font loads, begin and cursor-only characters do not hold up the next beat.
// The first row of a character passes the job, stage-one and output registers.
// Reset is synchronous; the font store is not cleared and holds junk until
// loaded. A stalled output holds its beat while one more row waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_glyph_renderer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire tcgr_pkg::in_beat_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output tcgr_pkg::out_beat_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  tcgr_pkg::draw_job_t job;
  logic                job_load;
  logic                job_free;
  tcgr_pkg::font_wr_t  font_wr;
  tcgr_pkg::font_rd_t  font_rd;
  logic [7:0]          font_data;
  tcgr_pkg::draw_cfg_t dcfg;
  logic                in_fire;

  // input beats wait only on the row generator
  assign in_ready  = job_free;
  assign in_fire   = in_valid && job_free;
  assign cfg_ready = 1'b1;

  tcgr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .job       (job),
    .job_load  (job_load),
    .font_wr   (font_wr),
    .dcfg      (dcfg)
  );

  tcgr_font u_font (
    .clk     (clk),
    .wr      (font_wr),
    .rd      (font_rd),
    .rd_data (font_data)
  );

  tcgr_rowgen u_rowgen (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_load  (job_load),
    .dcfg      (dcfg),
    .job_free  (job_free),
    .font_rd   (font_rd),
    .font_data (font_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console glyph renderer. A font preload
// and a short directed table come first, then random phases over several
// screen geometries and drawing settings. Every accepted beat goes through a
// cycle-free console predictor, and each glyph-row beat out of the block is
// compared field by field with the oldest predicted row.
// ----------------------------------------------------------------------------

module tb_top;
  import tcgr_pkg::*;

  // opcode and register index that the block must ignore
  localparam logic [1:0]           OP_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_val;
    in_beat_t             beat;
    bit                   typed;
    int                   exp_n;
    int                   exp_index;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_beat_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_beat_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // console mirror: registers, cursor and font
  logic [SCR_W-1:0]    con_width;
  logic [SCR_W-1:0]    con_height;
  logic [STRIDE_W-1:0] con_stride;
  logic                con_rec;
  logic                con_map;
  logic [31:0]         con_fg;
  logic [31:0]         con_bg;
  logic [COL_W-1:0]    con_col;
  logic [ROW_W-1:0]    con_row;
  logic [7:0]          font_mirror [STORE_DEPTH];
  bit                  font_known [STORE_DEPTH];

  out_beat_t step_rows [FONT_H];
  int        step_count;
  out_beat_t rows_due [$];
  out_beat_t row_want;

  logic [7:0] preload_set [6];
  plan_row_t  dir_plan [$];
  int         err_count;
  int         send_idle;
  int         recv_idle;
  int         quiet_cycles;

  text_console_glyph_renderer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // codes outside the printable range draw the substitute glyph
  function automatic logic [7:0] glyph_of(logic [7:0] code);
    return (code < CH_FIRST || code > CH_LAST) ? CH_SUBST : code;
  endfunction

  function automatic bit glyph_ready(logic [7:0] code);
    int base;
    base = int'(glyph_of(code) - CH_FIRST) * FONT_H;
    for (int y = 0; y < FONT_H; y++)
      if (!font_known[base + y]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic next_line(int rows);
    con_col = '0;
    if (int'(con_row) + 1 >= rows) con_row = ROW_W'(rows - 1);
    else con_row = con_row + 1'b1;
  endtask

  // console predictor: one input beat, fills step_rows with the rows it draws
  task automatic console_step(in_beat_t b);
    int         cols;
    int         rows;
    int         base;
    logic [63:0] idx;
    step_count = 0;
    case (b.opcode)
      OP_FONT_LOAD: begin
        if (b.char_code >= CH_FIRST && b.char_code <= CH_LAST && int'(b.glyph_row) < FONT_H) begin
          base = int'(b.char_code - CH_FIRST) * FONT_H + int'(b.glyph_row);
          font_mirror[base] = b.row_bits;
          font_known[base]  = 1'b1;
        end
      end
      OP_BEGIN: begin
        if (con_map && con_rec && con_width != 0 && con_height != 0 && con_stride != 0) begin
          con_col = COL_W'(1);
          con_row = ROW_W'(1);
          con_fg  = FG_DEFAULT;
          con_bg  = BG_DEFAULT;
        end
      end
      OP_WRITE_CHAR: begin
        cols = int'(con_width) / FONT_W;
        rows = int'(con_height) / FONT_H;
        if (con_rec && cols != 0 && rows != 0) begin
          if (b.char_code == CH_CR) begin
            con_col = '0;
          end else if (b.char_code == CH_LF) begin
            next_line(rows);
          end else begin
            // wrap at the right edge, then give up below the bottom row
            if (int'(con_col) >= cols) next_line(rows);
            if (int'(con_row) < rows) begin
              if (con_map && con_stride != 0) begin
                base = int'(glyph_of(b.char_code) - CH_FIRST) * FONT_H;
                for (int y = 0; y < FONT_H; y++) begin
                  idx = (64'(con_row) * FONT_H + 64'(y)) * 64'(con_stride)
                        + 64'(con_col) * FONT_W;
                  step_rows[y].word_index = idx[IDX_W-1:0];
                  step_rows[y].pattern    = font_mirror[base + y];
                  step_rows[y].fg_value   = con_fg;
                  step_rows[y].bg_value   = con_bg;
                  step_rows[y].last_row   = (y == FONT_H - 1);
                end
                step_count = FONT_H;
              end
              con_col = con_col + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // one input beat: optional gap, hold until taken, then predict
  task automatic send_item(in_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    console_step(b);
    for (int y = 0; y < step_count; y++) rows_due.push_back(step_rows[y]);
  endtask

  // wait until every predicted row has come out, plus the pipeline tail
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCREEN_WIDTH:  con_width  = data[SCR_W-1:0];
      REG_SCREEN_HEIGHT: con_height = data[SCR_W-1:0];
      REG_STRIDE:        con_stride = data[STRIDE_W-1:0];
      REG_FB_RECORDED:   con_rec    = data[0];
      REG_FB_MAPPED:     con_map    = data[0];
      REG_FG_COLOR:      con_fg     = data;
      REG_BG_COLOR:      con_bg     = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    plan_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.beat    = '0;
    r.typed   = 1'b0;
    r.exp_n   = 0;
    r.exp_index = 0;
    return r;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] op, logic [7:0] code, logic [3:0] grow,
                                         logic [7:0] bits, int n, int first_index);
    plan_row_t r;
    r.is_cfg    = 1'b0;
    r.reg_idx   = '0;
    r.reg_val   = '0;
    r.beat      = '{opcode: op, char_code: code, glyph_row: grow, row_bits: bits};
    r.typed     = 1'b1;
    r.exp_n     = n;
    r.exp_index = first_index;
    return r;
  endfunction

  // mostly drawable text, some control codes, font loads, begins and reserved opcodes
  function automatic in_beat_t random_item(bit lf_heavy);
    in_beat_t b;
    int       pick;
    b.opcode    = OP_WRITE_CHAR;
    b.char_code = 8'($urandom);
    b.glyph_row = 4'($urandom);
    b.row_bits  = 8'($urandom);
    pick = $urandom_range(99);
    if (lf_heavy && pick < 40) begin
      b.char_code = CH_LF;
    end else if (pick < 55) begin
      b.char_code = 8'($urandom_range(CH_FIRST, CH_LAST));
      if (!glyph_ready(b.char_code)) b.char_code = preload_set[$urandom_range(5)];
    end else if (pick < 65) begin
      // non-printable but not a cursor control
      if (b.char_code >= CH_FIRST && b.char_code <= CH_LAST) b.char_code ^= 8'h80;
      if (b.char_code == CH_LF || b.char_code == CH_CR) b.char_code ^= 8'h10;
    end else if (pick < 72) begin
      b.char_code = CH_CR;
    end else if (pick < 80) begin
      b.char_code = CH_LF;
    end else if (pick < 90) begin
      b.opcode = OP_FONT_LOAD;
      if ($urandom_range(3) != 0) b.char_code = 8'($urandom_range(CH_FIRST, CH_LAST));
    end else if (pick < 95) begin
      b.opcode = OP_BEGIN;
    end else begin
      b.opcode = OP_RESERVED;
    end
    // never draw a glyph with rows still unloaded
    if (b.opcode == OP_WRITE_CHAR && !glyph_ready(b.char_code)) b.char_code = CH_SUBST;
    return b;
  endfunction

  task automatic run_phase(int w, int h, int s, bit rec, bit map, int n, bit lf_heavy);
    write_reg(REG_SCREEN_WIDTH, 32'(w));
    write_reg(REG_SCREEN_HEIGHT, 32'(h));
    write_reg(REG_STRIDE, 32'(s));
    write_reg(REG_FB_RECORDED, 32'(rec));
    write_reg(REG_FB_MAPPED, 32'(map));
    write_reg(REG_FG_COLOR, $urandom);
    write_reg(REG_BG_COLOR, $urandom);
    repeat (n) send_item(random_item(lf_heavy));
  endtask

  // result side: random back-pressure
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // glyph-row beat check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (rows_due.size() == 0) begin
        flag_error($sformatf("beat with nothing expected, word_index %0h",
                             out_data.word_index));
      end else begin
        row_want = rows_due.pop_front();
        if (out_data.word_index !== row_want.word_index)
          flag_error($sformatf("word_index %0h, want %0h",
                               out_data.word_index, row_want.word_index));
        if (out_data.pattern !== row_want.pattern)
          flag_error($sformatf("pattern %0h, want %0h", out_data.pattern, row_want.pattern));
        if (out_data.fg_value !== row_want.fg_value)
          flag_error($sformatf("fg_value %0h, want %0h",
                               out_data.fg_value, row_want.fg_value));
        if (out_data.bg_value !== row_want.bg_value)
          flag_error($sformatf("bg_value %0h, want %0h",
                               out_data.bg_value, row_want.bg_value));
        if (out_data.last_row !== row_want.last_row)
          flag_error($sformatf("last_row %0b, want %0b", out_data.last_row, row_want.last_row));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** text_console_glyph_renderer: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    out_ready    = 1'b0;
    send_idle    = 0;
    recv_idle    = 0;
    err_count    = 0;
    quiet_cycles = 0;
    con_width    = '0;
    con_height   = '0;
    con_stride   = '0;
    con_rec      = 1'b0;
    con_map      = 1'b0;
    con_fg       = FG_DEFAULT;
    con_bg       = BG_DEFAULT;
    con_col      = '0;
    con_row      = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      font_known[i]  = 1'b0;
      font_mirror[i] = '0;
    end
    preload_set = '{CH_SUBST, CH_FIRST, CH_LAST, 8'h41, 8'h7A, 8'h30};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender lightly idle and receiver heavily stalled
    send_idle = 34;
    recv_idle = 60;

    // font preload: substitute glyph, both range ends, two letters and a digit
    foreach (preload_set[g])
      for (int y = 0; y < FONT_H; y++)
        send_item('{opcode: OP_FONT_LOAD, char_code: preload_set[g],
                    glyph_row: 4'(y), row_bits: 8'($urandom)});

    // directed table, 4 columns by 2 rows with a 64-pixel stride
    dir_plan.push_back(item_row(OP_WRITE_CHAR, 8'h41, 4'h0, 8'h00, 0, 0));
    dir_plan.push_back(item_row(OP_BEGIN, 8'h00, 4'h0, 8'h00, 0, 0));
    dir_plan.push_back(cfg_row(REG_SCREEN_WIDTH, 32'd32));
    dir_plan.push_back(cfg_row(REG_SCREEN_HEIGHT, 32'd32));
    dir_plan.push_back(cfg_row(REG_STRIDE, 32'd64));
    dir_plan.push_back(cfg_row(REG_FB_RECORDED, 32'd1));
    dir_plan.push_back(cfg_row(REG_FB_MAPPED, 32'd1));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, 8'h41, 4'h0, 8'h00, FONT_H, 0));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, 8'h00, 4'hF, 8'hFF, FONT_H, 8));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, CH_CR, 4'h0, 8'h00, 0, 0));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, CH_LAST, 4'h0, 8'h00, FONT_H, 0));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, CH_LF, 4'h0, 8'h00, 0, 0));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, CH_FIRST, 4'h0, 8'h00, FONT_H, 1024));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, CH_LF, 4'h0, 8'h00, 0, 0));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, 8'hFF, 4'h0, 8'h00, FONT_H, 1024));
    dir_plan.push_back(item_row(OP_BEGIN, 8'hFF, 4'hF, 8'hFF, 0, 0));
    dir_plan.push_back(cfg_row(REG_FG_COLOR, 32'h0000_0000));
    dir_plan.push_back(cfg_row(REG_BG_COLOR, 32'hFFFF_FFFF));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, 8'h7A, 4'h0, 8'h00, FONT_H, 1032));
    dir_plan.push_back(item_row(OP_FONT_LOAD, 8'h7F, 4'h0, 8'hFF, 0, 0));
    dir_plan.push_back(item_row(OP_FONT_LOAD, 8'h1F, 4'hF, 8'hFF, 0, 0));
    dir_plan.push_back(item_row(OP_RESERVED, 8'hFF, 4'hF, 8'hFF, 0, 0));
    dir_plan.push_back(item_row(OP_FONT_LOAD, CH_SUBST, 4'hF, 8'hFF, 0, 0));
    dir_plan.push_back(item_row(OP_FONT_LOAD, CH_SUBST, 4'h0, 8'h00, 0, 0));
    dir_plan.push_back(cfg_row(REG_UNUSED, 32'hDEAD_BEEF));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, CH_SUBST, 4'h0, 8'h00, FONT_H, 1040));
    dir_plan.push_back(item_row(OP_WRITE_CHAR, 8'h41, 4'h0, 8'h00, FONT_H, 1048));
    // right edge wrap with the new line clipped at the bottom row
    dir_plan.push_back(item_row(OP_WRITE_CHAR, 8'h41, 4'h0, 8'h00, FONT_H, 1024));

    foreach (dir_plan[i]) begin
      if (dir_plan[i].is_cfg) begin
        write_reg(dir_plan[i].reg_idx, dir_plan[i].reg_val);
      end else begin
        send_item(dir_plan[i].beat);
        if (dir_plan[i].typed) begin
          if (step_count != dir_plan[i].exp_n)
            flag_error($sformatf("table row %0d: %0d rows predicted, table gives %0d",
                                 i, step_count, dir_plan[i].exp_n));
          else if (step_count != 0 && int'(step_rows[0].word_index) != dir_plan[i].exp_index)
            flag_error($sformatf("table row %0d: first word_index %0h, table gives %0h",
                                 i, step_rows[0].word_index, dir_plan[i].exp_index));
        end
      end
    end

    // random phases, sender lightly idle and receiver heavily stalled
    run_phase(32, 48, 40, 1'b1, 1'b1, 20, 1'b0);
    run_phase(4096, 4096, 8192, 1'b1, 1'b1, 15, 1'b1);
    run_phase(24, 16, 24, 1'b1, 1'b1, 15, 1'b0);

    // the other way round
    send_idle = 60;
    recv_idle = 34;
    run_phase(8, 16, 1, 1'b1, 1'b1, 12, 1'b0);
    run_phase(40, 64, 100, 1'b1, 1'b0, 10, 1'b0);
    run_phase(40, 64, 0, 1'b1, 1'b1, 8, 1'b0);

    // no idling on either side
    send_idle = 0;
    recv_idle = 0;
    run_phase(40, 64, 100, 1'b0, 1'b1, 5, 1'b0);
    run_phase(7, 4096, 8192, 1'b1, 1'b1, 5, 1'b0);
    run_phase(64, 15, 64, 1'b1, 1'b1, 5, 1'b0);
    run_phase(80, 80, 8191, 1'b1, 1'b1, 19, 1'b0);

    settle();
    if (err_count == 0) begin
      $display("** text_console_glyph_renderer: PASSED **");
    end else begin
      $display("** text_console_glyph_renderer: FAILED **");
    end
    $finish;
  end

endmodule
